[hdl/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared constants, types and round functions for the byte-stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Request from the front part: one block of sixteen words to compress.
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } blk_req_t;

  typedef logic [31:0] word_t;

  function automatic logic [255:0] initial_hash();
    return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

[hdl/sha256_if.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface
`default_nettype wire

[hdl/sha256_front.sv]
// ----------------------------------------------------------------------------
// SHA-256 front part
// Packs bytes into blocks, counts bits and appends padding and length.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  last_byte,
  output logic                       blk_valid,
  input  wire logic                  blk_ready,
  output sha256_pkg::blk_req_t       blk_req
);

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;

  logic [1:0]   state_r, state_nxt;
  logic [511:0] buf_r, buf_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic         out_v_r, out_v_nxt;
  sha256_pkg::blk_req_t req_r, req_nxt;

  // The output slot is free when empty or being taken.
  logic slot_free;
  assign slot_free = !out_v_r || blk_ready;
  assign in_ready  = (state_r == ST_FILL) && slot_free;
  assign blk_valid = out_v_r;
  assign blk_req   = req_r;

  always_comb begin
    logic [511:0] b;
    logic [6:0]   f;
    state_nxt = state_r;
    buf_nxt   = buf_r;
    fill_nxt  = fill_r;
    bits_nxt  = bits_r;
    out_v_nxt = out_v_r && !blk_ready;
    req_nxt   = req_r;
    b = buf_r;
    f = '0;
    unique case (state_r)
      ST_FILL: begin
        if (in_valid && in_ready) begin
          b[511 - 8*fill_r -: 8] = data_byte;
          bits_nxt = bits_r + 64'd8;
          if (fill_r == 6'd63) begin
            req_nxt   = '{block: b, final_blk: 1'b0};
            out_v_nxt = 1'b1;
            fill_nxt  = 6'd0;
            state_nxt = last_byte ? ST_PAD : ST_FILL;
            buf_nxt   = b;
          end else if (last_byte) begin
            f = {1'b0, fill_r} + 7'd1;
            b[511 - 8*f[5:0] -: 8] = sha256_pkg::PAD_BYTE;
            for (int i = 0; i < 64; i++) begin
              if (i > int'(f)) b[511 - 8*i -: 8] = 8'h00;
            end
            if (f > 7'd55) begin
              req_nxt   = '{block: b, final_blk: 1'b0};
              out_v_nxt = 1'b1;
              state_nxt = ST_LEN;
            end else begin
              b[63:0]   = bits_nxt;
              req_nxt   = '{block: b, final_blk: 1'b1};
              out_v_nxt = 1'b1;
              bits_nxt  = 64'd0;
            end
            fill_nxt = 6'd0;
          end else begin
            buf_nxt  = b;
            fill_nxt = fill_r + 6'd1;
          end
        end
      end
      ST_PAD: begin
        if (slot_free) begin
          req_nxt   = '{block: {sha256_pkg::PAD_BYTE, 440'd0, bits_r}, final_blk: 1'b1};
          out_v_nxt = 1'b1;
          bits_nxt  = 64'd0;
          state_nxt = ST_FILL;
        end
      end
      ST_LEN: begin
        if (slot_free) begin
          req_nxt   = '{block: {448'd0, bits_r}, final_blk: 1'b1};
          out_v_nxt = 1'b1;
          bits_nxt  = 64'd0;
          state_nxt = ST_FILL;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      fill_r  <= '0;
      bits_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
      out_v_r <= out_v_nxt;
    end
    buf_r <= buf_nxt;
    req_r <= req_nxt;
  end

endmodule
`default_nettype wire

[hdl/sha256_queue.sv]
// ----------------------------------------------------------------------------
// SHA-256 block queue
// Short queue of block requests between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_queue #(
  parameter int unsigned DEPTH = sha256_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_valid,
  output logic                      wr_ready,
  input  wire sha256_pkg::blk_req_t wr_req,
  output logic                      rd_valid,
  input  wire logic                 rd_ready,
  output sha256_pkg::blk_req_t      rd_req
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha256_pkg::blk_req_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic do_wr, do_rd;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;
  assign rd_req = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (do_rd) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule
`default_nettype wire

[hdl/sha256_back.sv]
// ----------------------------------------------------------------------------
// SHA-256 back part
// Runs 64 rounds per block, one a cycle, and streams out the digest.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 blk_valid,
  output logic                      blk_ready,
  input  wire sha256_pkg::blk_req_t blk_req,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [31:0]               digest_word,
  output logic [2:0]                word_index,
  output logic                      last_word
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]   state_r;
  logic [5:0]   rnd_r;
  logic [2:0]   idx_r;
  logic         fin_r;
  logic [255:0] hash_r;
  logic [511:0] win_r;
  sha256_pkg::word_t a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;

  sha256_pkg::word_t w, t1, t2, s0, s1, wn;

  assign blk_ready   = (state_r == ST_IDLE);
  assign out_valid   = (state_r == ST_EMIT);
  assign digest_word = hash_r[255 - 32*idx_r -: 32];
  assign word_index  = idx_r;
  assign last_word   = (idx_r == 3'd7);

  always_comb begin
    w  = win_r[511:480];
    t1 = h_r + (sha256_pkg::rotr(e_r, 6) ^ sha256_pkg::rotr(e_r, 11)
         ^ sha256_pkg::rotr(e_r, 25)) + ((e_r & f_r) ^ (~e_r & g_r))
         + sha256_pkg::round_k(rnd_r) + w;
    t2 = (sha256_pkg::rotr(a_r, 2) ^ sha256_pkg::rotr(a_r, 13)
         ^ sha256_pkg::rotr(a_r, 22)) + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
    // Next schedule word from entries 0, 1, 9 and 14 (t-16, t-15, t-7, t-2).
    s0 = sha256_pkg::rotr(win_r[479:448], 7) ^ sha256_pkg::rotr(win_r[479:448], 18)
         ^ (win_r[479:448] >> 3);
    s1 = sha256_pkg::rotr(win_r[63:32], 17) ^ sha256_pkg::rotr(win_r[63:32], 19)
         ^ (win_r[63:32] >> 10);
    wn = s1 + win_r[223:192] + s0 + w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hash_r  <= sha256_pkg::initial_hash();
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (blk_valid) begin
            state_r <= ST_ROUND;
            rnd_r   <= '0;
          end
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= ST_ADD;
        end
        ST_ADD: begin
          hash_r <= {hash_r[255:224] + a_r, hash_r[223:192] + b_r,
                     hash_r[191:160] + c_r, hash_r[159:128] + d_r,
                     hash_r[127:96] + e_r, hash_r[95:64] + f_r,
                     hash_r[63:32] + g_r, hash_r[31:0] + h_r};
          idx_r   <= '0;
          state_r <= fin_r ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              hash_r  <= sha256_pkg::initial_hash();
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && blk_valid) begin
      win_r <= blk_req.block;
      fin_r <= blk_req.final_blk;
      {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <= hash_r;
    end else if (state_r == ST_ROUND) begin
      win_r <= {win_r[479:0], wn};
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
    end
  end

endmodule
`default_nettype wire

[hdl/sha256_byte_stream.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte-stream hasher
// Hashes a byte stream and returns the digest as eight words.
// ----------------------------------------------------------------------------
// Bytes arrive one per request, with last_byte set on the final byte of each
// message. The front part takes one byte per cycle, when its output slot is
// free and it is not padding, into a 64-byte block and hands full blocks,
// with padding and the 64-bit bit length added at the end of a message, to
// a short queue. The back part compresses each block with one round per
// cycle; the front part keeps taking bytes meanwhile until the queue is full,
// and a sustained stream runs at about one byte per cycle, bounded by that
// round loop. After the last byte the digest follows as eight word requests,
// word 0 first, last_word marking the eighth, and the hash is restored to its
// initial value for the next message. There is no clearing pass after reset.
`default_nettype none
module sha256_byte_stream #(
  parameter int unsigned QUEUE_DEPTH = sha256_pkg::QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sha256_in_if.sink   in_ch,
  sha256_out_if.source out_ch
);

  logic q_wv, q_wr, q_rv, q_rr;
  sha256_pkg::blk_req_t q_wd, q_rd;

  sha256_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .data_byte(in_ch.data_byte), .last_byte(in_ch.last_byte),
    .blk_valid(q_wv), .blk_ready(q_wr), .blk_req(q_wd)
  );

  sha256_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(q_wv), .wr_ready(q_wr), .wr_req(q_wd),
    .rd_valid(q_rv), .rd_ready(q_rr), .rd_req(q_rd)
  );

  sha256_back u_back (
    .clk(clk), .rst_n(rst_n),
    .blk_valid(q_rv), .blk_ready(q_rr), .blk_req(q_rd),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .digest_word(out_ch.digest_word), .word_index(out_ch.word_index),
    .last_word(out_ch.last_word)
  );

endmodule
`default_nettype wire

[bench/sha256_scoreboard.sv]
// ----------------------------------------------------------------------------
// SHA-256 digest scoreboard
// Predicts digest words from accepted message bytes and checks the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sha256_bench_pkg;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_req_t;

  class digest_scoreboard;
    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    int unsigned fill_count;
    logic [63:0] bit_count;
    digest_req_t pending_words [$];
    int unsigned error_count;

    function new();
      restart_hash();
      error_count = 0;
    endfunction

    function void restart_hash();
      logic [255:0] iv;
      iv = sha256_pkg::initial_hash();
      for (int i = 0; i < 8; i++) hash_state[i] = iv[255 - 32 * i -: 32];
      fill_count = 0;
      bit_count = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int t = 0; t < 16; t++)
        w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                block_bytes[4*t+3]};
      for (int t = 16; t < 64; t++) begin
        s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::round_k(t[5:0]) + w[t];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endfunction

    // Absorb one accepted byte; on the final byte pad, finish and queue the digest.
    function void note_byte(logic [7:0] data, logic last);
      digest_req_t r;
      block_bytes[fill_count] = data;
      fill_count++;
      bit_count += 64'd8;
      if (fill_count == 64) begin
        compress();
        fill_count = 0;
      end
      if (!last) return;
      block_bytes[fill_count] = sha256_pkg::PAD_BYTE;
      fill_count++;
      if (fill_count > 56) begin
        for (int i = fill_count; i < 64; i++) block_bytes[i] = 8'h00;
        compress();
        fill_count = 0;
      end
      for (int i = fill_count; i < 56; i++) block_bytes[i] = 8'h00;
      for (int i = 0; i < 8; i++) block_bytes[56 + i] = bit_count[63 - 8 * i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        r.digest_word = hash_state[i];
        r.word_index = i[2:0];
        r.last_word = (i == 7);
        pending_words.push_back(r);
      end
      restart_hash();
    endfunction

    function void check_word(digest_req_t got);
      digest_req_t exp;
      if (pending_words.size() == 0) begin
        $error("digest word %h arrived with nothing expected", got.digest_word);
        error_count++;
        return;
      end
      exp = pending_words.pop_front();
      if (got.digest_word !== exp.digest_word) begin
        $error("digest_word: expected %h, got %h", exp.digest_word, got.digest_word);
        error_count++;
      end
      if (got.word_index !== exp.word_index) begin
        $error("word_index: expected %0d, got %0d", exp.word_index, got.word_index);
        error_count++;
      end
      if (got.last_word !== exp.last_word) begin
        $error("last_word: expected %0d, got %0d", exp.last_word, got.last_word);
        error_count++;
      end
    endfunction
  endclass

endpackage

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte-stream testbench
// Streams messages through the hasher and checks every digest word.
// ----------------------------------------------------------------------------
// Messages of several lengths are sent byte by byte. Directed messages cover
// one byte, the padding boundary at 55 and 56 bytes, a block filling exactly
// on the last byte and all-zero and all-one bytes. Short random messages
// follow. The sender bursts and pauses, and the receiver stalls on its own
// pattern.
`timescale 1ns / 1ps
module testbench;

  logic clk;
  logic rst_n;
  logic rx_stall_mode;
  int   rx_count;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  sha256_byte_stream u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  sha256_bench_pkg::digest_scoreboard board;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Generous ceiling, far beyond what the messages need.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: acceptance is sampled on the edge, ready then changes after it.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_count <= 0;
      rx_stall_mode <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        board.check_word({out_ch.digest_word, out_ch.word_index, out_ch.last_word});
      rx_count <= rx_count + 1;
      // Alternate stretches of free running with stretches of heavy stalling.
      if (rx_count % 300 == 0) rx_stall_mode <= $urandom_range(0, 1);
      out_ch.ready <= rx_stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  int burst_left;

  // Send one byte; holds valid across back-to-back requests within a burst.
  task automatic send_byte(input logic [7:0] data, input logic last);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_byte(data, last);
    burst_left--;
  endtask

  // kind 0: random bytes, 1: all zero, 2: all ones.
  task automatic send_message(input int len, input int kind);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (kind == 1) ? 8'h00 : (kind == 2) ? 8'hff : 8'($urandom_range(0, 255));
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (board.pending_words.size() != 0) @(posedge clk);
  endtask

  int len;
  int waited;

  initial begin
    board = new();
    burst_left = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single byte at both extremes, then the padding boundaries.
    send_message(1, 1);
    send_message(1, 2);
    send_message(3, 0);
    wait_drained();
    send_message(55, 2);
    send_message(56, 1);
    send_message(64, 0);

    // Short random messages; a pause until drained part way through.
    for (int m = 0; m < 8; m++) begin
      len = $urandom_range(1, 10);
      send_message(len, 0);
      if (m == 4) wait_drained();
    end

    wait_drained();
    waited = 0;
    while (waited < 200) begin
      @(posedge clk);
      waited++;
    end
    if (board.error_count == 0 && board.pending_words.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
